// ===== src/frwa_pkg.sv =====
// Shared constants and types for the frame rate window averager.
// No dependencies; imported by every module of the block except frwa_ram.
package frwa_pkg;

  localparam int unsigned Window    = 60;
  localparam int unsigned StampW    = 32;
  localparam int unsigned SlotW     = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned CntW      = $clog2(Window + 1);
  localparam int unsigned SumW      = StampW + CntW;
  localparam int unsigned MsPerS    = 1000;
  localparam int unsigned MsW       = 10;
  localparam int unsigned FracW     = 16;
  localparam int unsigned NumW      = CntW + MsW + FracW;
  localparam int unsigned ItW       = $clog2(NumW);
  localparam int unsigned RateLimit = 65536000;
  localparam int unsigned FpsW      = 26;
  localparam int unsigned FramesW   = 6;
  localparam int unsigned FifoPtrW  = 1;
  localparam int unsigned FifoDepth = 2 ** FifoPtrW;

  typedef struct packed {
    logic [StampW-1:0] delay;
    logic [SlotW-1:0]  slot;
    logic [CntW-1:0]   count;
    logic              full;
  } frwa_item_t;

endpackage

// ===== src/frame_rate_window_average.sv =====
// Top level of the moving-average frame rate counter.
// Depends on frwa_pkg, frwa_front, frwa_fifo, frwa_back, frwa_ram.
//
//  channel   | dir | payload
//  s_axis    | in  | tdata[31:0] now_ms
//  m_axis    | out | tdata[31:0] frame_delay, [37:32] frames_counted, [63:38] fps_q16;
//            |     | tuser[0] zero_sum
//  cfg       | in  | cfg_wdata_i[31:0] start_stamp, written when cfg_we_i is high
//
// Each stamp passes through the back end in order: ring read, sum subtract, sum
// add, the restoring divider at one quotient bit per cycle, and output load, which
// waits while a result is held, before the next stamp is taken. The front end
// takes stamps while the two-entry queue has room, so a waiting result stalls the
// back end, and the front end once the queue is full. Reset clears the sum, fill
// count and slot; the ring needs no clearing pass since unfilled slots read as zero.
module frame_rate_window_average import frwa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,   // start_stamp
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] now_ms
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // [31:0] frame_delay, [37:32] frames_counted,
                                     // [63:38] fps_q16
  output logic [0:0]  m_axis_tuser   // [0] zero_sum
);

  logic               push;
  logic               q_full;
  logic               q_valid;
  logic               pop;
  frwa_item_t         push_item;
  frwa_item_t         head_item;
  logic [StampW-1:0]  out_delay;
  logic [FramesW-1:0] out_frames;
  logic [FpsW-1:0]    out_fps;
  logic               out_zero;

  frwa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .valid_i      (s_axis_tvalid),
    .now_i        (s_axis_tdata),
    .queue_full_i (q_full),
    .ready_o      (s_axis_tready),
    .push_o       (push),
    .item_o       (push_item)
  );

  frwa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  frwa_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_delay_o  (out_delay),
    .out_frames_o (out_frames),
    .out_fps_o    (out_fps),
    .out_zero_o   (out_zero)
  );

  assign m_axis_tdata = {out_fps, out_frames, out_delay};
  assign m_axis_tuser = out_zero;

endmodule

// ===== src/frwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frwa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                           wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/frwa_front.sv =====
// Front end: accepts stamps, forms the delay, tracks last stamp, ring slot and fill count.
// Depends on frwa_pkg.
module frwa_front import frwa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [StampW-1:0] cfg_wdata_i,
  input  logic              valid_i,
  input  logic [StampW-1:0] now_i,
  input  logic              queue_full_i,
  output logic              ready_o,
  output logic              push_o,
  output frwa_item_t        item_o
);

  logic [StampW-1:0] last_q, last_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              full;

  assign ready_o = !queue_full_i;
  assign push_o  = valid_i && ready_o;
  assign full    = (cnt_q == CntW'(Window));

  always_comb begin
    last_d = last_q;
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (cfg_we_i) begin
      last_d = cfg_wdata_i;
    end else if (push_o) begin
      last_d = now_i;
      slot_d = (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + SlotW'(1);
      cnt_d  = full ? cnt_q : cnt_q + CntW'(1);
    end
  end

  always_comb begin
    item_o.delay = now_i - last_q;
    item_o.slot  = slot_q;
    item_o.count = cnt_d;
    item_o.full  = full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      slot_q <= '0;
      cnt_q  <= '0;
    end else begin
      last_q <= last_d;
      slot_q <= slot_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== src/frwa_fifo.sv =====
// Short queue of classified items between front and back end.
// Depends on frwa_pkg.
module frwa_fifo import frwa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  frwa_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       valid_o,
  output frwa_item_t item_o
);

  frwa_item_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wptr_q, rptr_q;
  logic [FifoPtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (FifoPtrW + 1)'(FifoDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + FifoPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + FifoPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FifoPtrW + 1)'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - (FifoPtrW + 1)'(1);
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) full_o |-> !push_i)
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !valid_o |-> !pop_i)
    else $error("queue underflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && !full_o) |=> valid_o)
    else $error("pushed item lost");

endmodule

// ===== src/frwa_back.sv =====
// Back end: ring update, running sum, restoring divider and output register.
// Depends on frwa_pkg and frwa_ram.
module frwa_back import frwa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  frwa_item_t         item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StampW-1:0]  out_delay_o,
  output logic [FramesW-1:0] out_frames_o,
  output logic [FpsW-1:0]    out_fps_o,
  output logic               out_zero_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e             state_q;
  frwa_item_t         itm_q;
  logic [SumW-1:0]    sum_q;
  logic [SumW-1:0]    rem_q;
  logic [NumW-1:0]    num_q;
  logic [ItW-1:0]     it_q;
  logic [StampW-1:0]  ram_rdata;
  logic [StampW-1:0]  old_delay;
  logic               ram_we;
  logic [SumW:0]      rem_sh;
  logic               qbit;
  logic [NumW-1:0]    quot_sat;
  logic               out_load;

  logic               out_vld_q;
  logic [StampW-1:0]  out_delay_q;
  logic [FramesW-1:0] out_frames_q;
  logic [FpsW-1:0]    out_fps_q;
  logic               out_zero_q;

  assign pop_o     = (state_q == ST_IDLE) && item_valid_i;
  assign ram_we    = (state_q == ST_SUB);
  // slots at or beyond the fill count were never written and read as zero
  assign old_delay = itm_q.full ? ram_rdata : '0;
  assign rem_sh    = {rem_q, num_q[NumW-1]};
  assign qbit      = (rem_sh >= {1'b0, sum_q});
  assign quot_sat  = (num_q > NumW'(RateLimit)) ? NumW'(RateLimit) : num_q;
  assign out_load  = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);

  frwa_ram #(
    .Width (StampW),
    .Depth (Window)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (itm_q.slot),
    .wdata_i (itm_q.delay),
    .raddr_i (item_i.slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          itm_q <= item_i;
        end
      end
      ST_ADD: begin
        num_q <= (NumW'(itm_q.count) * NumW'(MsPerS)) << FracW;
        rem_q <= '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? SumW'(rem_sh - {1'b0, sum_q}) : rem_sh[SumW-1:0];
        num_q <= {num_q[NumW-2:0], qbit};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      sum_q        <= '0;
      it_q         <= '0;
      out_vld_q    <= 1'b0;
      out_delay_q  <= '0;
      out_frames_q <= '0;
      out_fps_q    <= '0;
      out_zero_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            state_q <= ST_SUB;
          end
        end
        ST_SUB: begin
          sum_q   <= sum_q - SumW'(old_delay);
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          sum_q   <= sum_q + SumW'(itm_q.delay);
          it_q    <= ItW'(NumW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          it_q <= it_q - ItW'(1);
          if (it_q == '0) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_delay_q  <= itm_q.delay;
            out_frames_q <= FramesW'(itm_q.count);
            out_fps_q    <= FpsW'(quot_sat);
            out_zero_q   <= (sum_q == '0);
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_delay_o  = out_delay_q;
  assign out_frames_o = out_frames_q;
  assign out_fps_o    = out_fps_q;
  assign out_zero_o   = out_zero_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (NumW'(out_fps_q) <= NumW'(RateLimit)))
    else $error("rate above limit");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_zero_q) |-> (NumW'(out_fps_q) == NumW'(RateLimit)))
    else $error("zero sum without saturated rate");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !out_vld_q) |=> (out_vld_q && state_q == ST_IDLE))
    else $error("result not registered");

endmodule

// ===== tb/sv/frwa_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the frame rate window averager: mirrors the delay ring, running sum,
// fill count and last stamp from the observed transactions and checks every result.
// Depends on frwa_pkg.
module frwa_checker import frwa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [31:0] s_data_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [63:0] m_data_i,
  input  logic [0:0]  m_user_i,
  output int unsigned fail_count_o,
  output int unsigned results_seen_o
);

  typedef struct packed {
    logic [StampW-1:0]  delay;
    logic [FramesW-1:0] frames;
    logic [FpsW-1:0]    fps;
    logic               zero_sum;
  } rate_result_t;

  logic [StampW-1:0] delay_ring [Window];
  logic [63:0]       delay_sum;
  int unsigned       write_slot;
  int unsigned       filled;
  logic [StampW-1:0] last_stamp;
  rate_result_t      expected_rates [512];
  int unsigned       exp_head;
  int unsigned       exp_tail;

  function automatic rate_result_t advance_window(logic [StampW-1:0] now);
    rate_result_t r;
    logic [63:0]  quot;
    r.delay = now - last_stamp;
    delay_sum = delay_sum - 64'(delay_ring[write_slot]) + 64'(r.delay);
    delay_ring[write_slot] = r.delay;
    write_slot = (write_slot + 1 >= Window) ? 0 : write_slot + 1;
    last_stamp = now;
    if (filled < Window) filled++;
    r.frames = filled[FramesW-1:0];
    if (delay_sum == 64'd0) begin
      r.fps = FpsW'(RateLimit);
      r.zero_sum = 1'b1;
    end else begin
      quot = (64'(MsPerS) * 64'(filled) * 64'd65536) / delay_sum;
      if (quot > 64'(RateLimit)) quot = 64'(RateLimit);
      r.fps = quot[FpsW-1:0];
      r.zero_sum = 1'b0;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    rate_result_t got;
    rate_result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) delay_ring[i] = '0;
      delay_sum = '0;
      write_slot = 0;
      filled = 0;
      last_stamp = '0;
      exp_head = 0;
      exp_tail = 0;
      fail_count_o <= 0;
      results_seen_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        got = {m_data_i[31:0], m_data_i[37:32], m_data_i[63:38], m_user_i[0]};
        results_seen_o <= results_seen_o + 1;
        if (exp_tail == exp_head) begin
          $display("%0t: unexpected result, expected none, got delay %h frames %0d",
                   $time, got.delay, got.frames);
          $display("%0t: unexpected result, got fps %h zero %b",
                   $time, got.fps, got.zero_sum);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_rates[exp_head % $size(expected_rates)];
          exp_head++;
          if (got !== want) begin
            $display("%0t: mismatch delay exp %h got %h, frames exp %0d got %0d",
                     $time, want.delay, got.delay, want.frames, got.frames);
            $display("%0t: mismatch fps exp %h got %h, zero_sum exp %b got %b",
                     $time, want.fps, got.fps, want.zero_sum, got.zero_sum);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (cfg_we_i) last_stamp = cfg_wdata_i;
      if (s_valid_i && s_ready_i) begin
        expected_rates[exp_tail % $size(expected_rates)] = advance_window(s_data_i);
        exp_tail++;
      end
    end
  end

endmodule

// ===== tb/sv/tb_frame_rate_window_average.sv =====
`timescale 1ns / 100ps
// Testbench top for frame_rate_window_average: drives stamps and start_stamp writes
// with random idling and back-pressure; frwa_checker predicts and compares results.
// Depends on frwa_pkg, frwa_checker and the block's RTL.
module tb_frame_rate_window_average;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] now_ms
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // [31:0] frame_delay, [37:32] frames_counted,
                                    // [63:38] fps_q16
  logic [0:0]  m_axis_tuser;        // [0] zero_sum

  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned stamps_sent = 0;
  logic        idle_on = 1'b0;
  logic        stall_req = 1'b0;
  logic        stall_taken = 1'b0;
  int unsigned hold_left = 0;
  logic [31:0] tick;

  always #1 clk_i = ~clk_i;

  frame_rate_window_average u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  frwa_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_i      (s_axis_tready),
    .s_data_i       (s_axis_tdata),
    .m_valid_i      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_data_i       (m_axis_tdata),
    .m_user_i       (m_axis_tuser),
    .fail_count_o   (fail_count),
    .results_seen_o (results_seen)
  );

  // result sink: one long hold-off on request, otherwise random or steady ready
  always @(posedge clk_i) begin
    if (stall_req && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_left <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 32);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_stamp(input logic [31:0] stamp);
    while (idle_on && $urandom_range(0, 99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= stamp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    stamps_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (results_seen != stamps_sent) @(posedge clk_i);
  endtask

  task automatic write_start_stamp(input logic [31:0] stamp);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= stamp;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tick = stamp;
  endtask

  function automatic logic [31:0] next_tick(input logic [31:0] t);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return t + $urandom_range(8, 50);
    else if (pick < 70) return t + $urandom_range(0, 2);
    else if (pick < 80) return t;
    else if (pick < 92) return $urandom();
    else return t + $urandom_range(1000, 100000);
  endfunction

  task automatic run_stamps(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      tick = next_tick(tick);
      send_stamp(tick);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero sum, rate above the limit, wraps, extreme stamps
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0001);
    send_stamp(32'h0000_03E9);
    send_stamp(32'hFFFF_FFFF);
    send_stamp(32'h0000_0004);
    send_stamp(32'h8000_0000);
    send_stamp(32'h7FFF_FFFF);
    send_stamp(32'h5555_5555);
    send_stamp(32'hAAAA_AAAA);
    write_start_stamp(32'hFFFF_FFFF);
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0003);
    write_start_stamp(32'h0000_0000);
    send_stamp(32'h0000_0000);
    send_stamp(32'h0000_0010);

    write_start_stamp($urandom());
    idle_on <= 1'b1;
    run_stamps(140);

    idle_on <= 1'b0;
    run_stamps(60);

    // sink holds off while stamps keep coming, then the source waits for all results
    stall_req <= 1'b1;
    run_stamps(40);
    drain();

    // a full window of equal stamps drives the sum back to zero
    write_start_stamp(32'hFFFF_FFF0);
    idle_on <= 1'b1;
    for (int i = 0; i < 70; i++) send_stamp(32'hFFFF_FFF0);

    write_start_stamp($urandom());
    run_stamps(130);

    drain();
    repeat (64) @(posedge clk_i);
    if (results_seen != stamps_sent)
      $display("%0t: results missing, expected %0d got %0d", $time, stamps_sent, results_seen);
    if (fail_count == 0 && results_seen == stamps_sent) begin
      $display("tb_frame_rate_window_average OK");
    end else begin
      $display("tb_frame_rate_window_average NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_frame_rate_window_average NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
src/frwa_pkg.sv
src/frwa_ram.sv
src/frwa_front.sv
src/frwa_fifo.sv
src/frwa_back.sv
src/frame_rate_window_average.sv
tb/sv/frwa_checker.sv
tb/sv/tb_frame_rate_window_average.sv
